@@ rtl/spk_pkg.sv @@
// ----------------------------------------------------------------------------
// spk_pkg: shared types and constants for the Speck 128/128 core
// Round count, word and key store geometry, rotation helpers and the
// command struct that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spk_pkg;

  // Cipher geometry
  localparam int ROUNDS    = 32;
  localparam int WORD_W    = 64;
  localparam int KEY_DEPTH = 32;
  localparam int KEY_IDX_W = $clog2(KEY_DEPTH);

  // Rotation amounts of the round function
  localparam int ROT_X = 8;
  localparam int ROT_Y = 3;

  // Round counter wide enough for both a round index and a key index
  localparam int RND_BITS = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int RND_W    = (RND_BITS > KEY_IDX_W) ? RND_BITS : KEY_IDX_W;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [RND_W-1:0]     rnd_t;

  localparam rnd_t LAST_RND = RND_W'(ROUNDS - 1);

  // Input action codes
  localparam logic ACT_KEY   = 1'b0;
  localparam logic ACT_BLOCK = 1'b1;

  // Direction codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic key_we;    // write one round key
    logic blk_load;  // capture a new block into the x/y registers
    logic round_en;  // apply one round to x/y
    logic out_load;  // copy x/y into the output register
    rnd_t rd_round;  // round whose key is fetched this cycle
  } spk_cmd_t;

  function automatic word_t rotr_x(input word_t v);
    return (v >> ROT_X) | (v << (WORD_W - ROT_X));
  endfunction

  function automatic word_t rotl_x(input word_t v);
    return (v << ROT_X) | (v >> (WORD_W - ROT_X));
  endfunction

  function automatic word_t rotr_y(input word_t v);
    return (v >> ROT_Y) | (v << (WORD_W - ROT_Y));
  endfunction

  function automatic word_t rotl_y(input word_t v);
    return (v << ROT_Y) | (v >> (WORD_W - ROT_Y));
  endfunction

endpackage

`default_nettype wire

@@ rtl/speck128_block_cipher_core.sv @@
// ----------------------------------------------------------------------------
// speck128_block_cipher_core: Speck 128/128 with a loaded round key store
// Key write transactions fill the key store; block transactions are
// encrypted or decrypted according to the direction register.
// ----------------------------------------------------------------------------
//
//   channel  handshake                payload
//   -------  -----------------------  ---------------------------------------
//   in       in_valid_i / in_stall_o  action, key_index, key_word, block x/y
//   out      out_valid_o/ out_stall_i result_low, result_high
//   cfg      cfg_valid_i/ cfg_ready_o decrypt_mode (cfg_data_i)
//
// A key write is taken while idle and leaves the core idle. A block is loaded,
// passed through all ROUNDS rounds of the single round unit in turn, and then
// moved into the output register; the key memory read is registered and addressed with the upcoming round.
// A new transaction is taken while a result still waits on out_stall_i; a
// finished block holds until the output register is free.
// Reset clears the controller and the direction register; the key store is
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module speck128_block_cipher_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire spk_pkg::key_idx_t key_index_i,
  input  wire spk_pkg::word_t    key_word_i,
  input  wire spk_pkg::word_t    block_low_i,
  input  wire spk_pkg::word_t    block_high_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output spk_pkg::word_t         result_low_o,
  output spk_pkg::word_t         result_high_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i
);
  import spk_pkg::*;

  spk_cmd_t cmd;
  logic     cfg_we;

  // Accept configuration at any time
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  spk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  spk_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .key_index_i   (key_index_i),
    .key_word_i    (key_word_i),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o)
  );

endmodule

`default_nettype wire

@@ rtl/spk_ctrl.sv @@
// ----------------------------------------------------------------------------
// spk_ctrl: sequencer for the Speck 128/128 core
// Accepts transactions while idle, steps the round counter and hands the
// finished block to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module spk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          action_i,
  input  wire logic          out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output spk_pkg::spk_cmd_t  cmd_o
);
  import spk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  rnd_t   rnd_q, rnd_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take;
  logic   out_free;

  // Decode handshakes
  assign in_take  = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Drive datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.key_we   = in_take && (action_i == ACT_KEY);
    cmd_o.blk_load = in_take && (action_i == ACT_BLOCK);
    cmd_o.round_en = (state_q == ST_ROUND);
    cmd_o.out_load = (state_q == ST_DONE) && out_free;
    cmd_o.rd_round = (state_q == ST_ROUND) ? rnd_q + rnd_t'(1) : '0;
  end

  // Compute next state
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.blk_load) begin
          state_d = ST_ROUND;
          rnd_d   = '0;
        end
      end
      ST_ROUND: begin
        if (rnd_q == LAST_RND) begin
          state_d = ST_DONE;
        end else begin
          rnd_d = rnd_q + rnd_t'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/spk_datapath.sv @@
// ----------------------------------------------------------------------------
// spk_datapath: key store, round function and output register
// One Speck round per cycle on the x/y registers, keys fetched in the cycle
// before their round from a single-port-read key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module spk_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spk_pkg::spk_cmd_t cmd_i,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_data_i,
  input  wire spk_pkg::key_idx_t key_index_i,
  input  wire spk_pkg::word_t    key_word_i,
  input  wire spk_pkg::word_t    block_low_i,
  input  wire spk_pkg::word_t    block_high_i,
  output spk_pkg::word_t         result_low_o,
  output spk_pkg::word_t         result_high_o
);
  import spk_pkg::*;

  word_t    key_mem [KEY_DEPTH];
  word_t    key_q;
  key_idx_t rd_addr;
  rnd_t     rd_rev;
  logic     mode_q;
  word_t    x_q, x_d;
  word_t    y_q, y_d;
  word_t    enc_x, enc_y;
  word_t    dec_t, dec_u;
  word_t    dec_x, dec_y;
  word_t    res_lo_q, res_hi_q;

  // Hold direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Select key address: forward or reversed round order
  assign rd_rev  = LAST_RND - cmd_i.rd_round;
  assign rd_addr = (mode_q == MODE_DEC) ? rd_rev[KEY_IDX_W-1:0]
                                        : cmd_i.rd_round[KEY_IDX_W-1:0];

  // Write and read the key store
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      key_mem[key_index_i] <= key_word_i;
    end
    key_q <= key_mem[rd_addr];
  end

  // Forward round
  assign enc_x = (rotr_x(x_q) + y_q) ^ key_q;
  assign enc_y = rotl_y(y_q) ^ enc_x;

  // Inverse round
  assign dec_t = y_q ^ x_q;
  assign dec_y = rotr_y(dec_t);
  assign dec_u = (x_q ^ key_q) - dec_y;
  assign dec_x = rotl_x(dec_u);

  // Advance block state
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    priority if (cmd_i.blk_load) begin
      x_d = block_high_i;
      y_d = block_low_i;
    end else if (cmd_i.round_en) begin
      x_d = (mode_q == MODE_DEC) ? dec_x : enc_x;
      y_d = (mode_q == MODE_DEC) ? dec_y : enc_y;
    end else begin
      x_d = x_q;
      y_d = y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    if (cmd_i.out_load) begin
      res_lo_q <= y_q;
      res_hi_q <= x_q;
    end
  end

  assign result_low_o  = res_lo_q;
  assign result_high_o = res_hi_q;

endmodule

`default_nettype wire

@@ rtl/spk_checker.sv @@
// ----------------------------------------------------------------------------
// spk_checker: port-level assertions for the Speck 128/128 core
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module spk_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              action_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire spk_pkg::word_t    result_low_o,
  input wire spk_pkg::word_t    result_high_o
);
  import spk_pkg::*;

  logic blk_take;
  logic key_take;

  assign blk_take = in_valid_i && !in_stall_o && (action_i == ACT_BLOCK);
  assign key_take = in_valid_i && !in_stall_o && (action_i == ACT_KEY);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_low_o)
      && $stable(result_high_o))
    else $error("stalled result transaction changed");

  // A block transaction makes the core busy
  a_blk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_take |=> in_stall_o)
    else $error("core not busy after block transaction");

  // A key write transaction leaves the core ready
  a_key_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_take |=> !in_stall_o)
    else $error("core busy after key write transaction");

  // Leaving busy always delivers a result
  a_fell_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("busy ended without a result");

  // A new result only appears as a block finishes
  a_rose_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result appeared outside block completion");

endmodule

bind speck128_block_cipher_core spk_checker u_spk_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking regression for speck128_block_cipher_core
// Loads the round key store, runs corner and random blocks in both directions
// with random idle cycles on both channels, and checks every result against
// a cycle-free Speck 128/128 predictor kept in step with accepted traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spk_pkg::*;

  localparam int DRAIN_CYCLES = ROUNDS + 8;

  typedef struct {
    word_t low;
    word_t high;
  } speck_block_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  logic     action_i = ACT_KEY;
  key_idx_t key_index_i = '0;
  word_t    key_word_i = '0;
  word_t    block_low_i = '0;
  word_t    block_high_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  word_t    result_low_o;
  word_t    result_high_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic     cfg_data_i = MODE_ENC;

  // Mirror of the key store and the direction register
  word_t        key_mirror [KEY_DEPTH];
  logic         dir_mirror = MODE_ENC;
  speck_block_t expected_blocks [$];
  int           errors = 0;
  bit           rush = 1'b0;

  speck128_block_cipher_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_index_i   (key_index_i),
    .key_word_i    (key_word_i),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Idle cycles before the next transaction or of an output stall; none during a rush stretch
  function automatic int draw_wait();
    if (rush) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Run one block through all rounds with the mirrored keys
  function automatic speck_block_t speck_rounds(input logic dir, input word_t y_in,
                                                input word_t x_in);
    word_t        x;
    word_t        y;
    word_t        k;
    speck_block_t res;
    x = x_in;
    y = y_in;
    for (int r = 0; r < ROUNDS; r++) begin
      if (dir == MODE_ENC) begin
        k = key_mirror[key_idx_t'(r)];
        x = ({x[7:0], x[63:8]} + y) ^ k;
        y = {y[60:0], y[63:61]} ^ x;
      end else begin
        k = key_mirror[key_idx_t'(ROUNDS - 1 - r)];
        y = y ^ x;
        y = {y[2:0], y[63:3]};
        x = (x ^ k) - y;
        x = {x[55:0], x[63:56]};
      end
    end
    res.low  = y;
    res.high = x;
    return res;
  endfunction

  // Present one transaction, hold it until accepted, then update the mirror
  task automatic send_item(input logic act, input key_idx_t idx, input word_t kw,
                           input word_t lo, input word_t hi);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_index_i  <= idx;
    key_word_i   <= kw;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    if (act == ACT_KEY) begin
      key_mirror[idx] = kw;
    end else begin
      expected_blocks.push_back(speck_rounds(dir_mirror, lo, hi));
    end
  endtask

  task automatic write_key(input key_idx_t idx, input word_t kw);
    send_item(ACT_KEY, idx, kw, rand_word(), rand_word());
  endtask

  task automatic cipher_block(input word_t lo, input word_t hi);
    send_item(ACT_BLOCK, key_idx_t'($urandom), rand_word(), lo, hi);
  endtask

  // Drop valid and wait until every result is back and the core is quiet
  task automatic drain_core();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic dir);
    drain_core();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dir;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dir_mirror = dir;
  endtask

  // Fill every key entry, extremes at both ends of the index range
  task automatic test_load_keys();
    write_key(key_idx_t'(0), '0);
    for (int i = 1; i < KEY_DEPTH - 1; i++) begin
      write_key(key_idx_t'(i), rand_word());
    end
    write_key(key_idx_t'(KEY_DEPTH - 1), '1);
  endtask

  task automatic test_encrypt_corners();
    set_direction(MODE_ENC);
    cipher_block('0, '0);
    cipher_block('1, '1);
    cipher_block({32{2'b01}}, {32{2'b10}});
    cipher_block('0, '1);
    cipher_block(64'h1, 64'h8000_0000_0000_0000);
  endtask

  // Overwrite keys back to back with blocks so the new key must be used
  task automatic test_key_rewrite();
    rush = 1'b1;
    write_key(key_idx_t'(0), '1);
    cipher_block(rand_word(), rand_word());
    write_key(key_idx_t'(KEY_DEPTH - 1), '0);
    cipher_block(rand_word(), rand_word());
    write_key(key_idx_t'(KEY_DEPTH / 2), rand_word());
    cipher_block('1, '0);
    rush = 1'b0;
  endtask

  task automatic test_decrypt_corners();
    speck_block_t ct;
    word_t        lo;
    word_t        hi;
    set_direction(MODE_DEC);
    cipher_block('0, '0);
    cipher_block('1, '1);
    cipher_block({32{2'b10}}, {32{2'b01}});
    // Round trip: decrypting a predicted ciphertext gives the plaintext back
    lo = rand_word();
    hi = rand_word();
    ct = speck_rounds(MODE_ENC, lo, hi);
    cipher_block(ct.low, ct.high);
  endtask

  // Mostly blocks with random key updates, direction flipped per phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      set_direction((phase % 2 == 0) ? MODE_ENC : MODE_DEC);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          rush = !rush;
        end
        if ($urandom_range(0, 3) == 0) begin
          write_key(key_idx_t'($urandom), rand_word());
        end else begin
          cipher_block(rand_word(), rand_word());
        end
      end
      rush = 1'b0;
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    speck_block_t exp_blk;
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected result low %h high %h", $time, result_low_o,
               result_high_o);
      errors++;
    end else begin
      exp_blk = expected_blocks.pop_front();
      if (result_low_o !== exp_blk.low) begin
        $display("%0t: result_low expected %h actual %h", $time, exp_blk.low,
                 result_low_o);
        errors++;
      end
      if (result_high_o !== exp_blk.high) begin
        $display("%0t: result_high expected %h actual %h", $time, exp_blk.high,
                 result_high_o);
        errors++;
      end
    end
  endtask

  // Result side: check at the accepting edge, then stall for a random while
  initial begin : result_sink
    int hold;
    forever begin
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        check_result();
        @(posedge clk_i);
        hold = draw_wait();
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : regression
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_keys();
    test_encrypt_corners();
    test_key_rewrite();
    test_decrypt_corners();
    test_random_traffic();
    drain_core();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
